[src/tasc_pkg.sv]
// Shared types and constants for the two-axis servo command generator.
// No dependencies; used by the interfaces, the lane and the top level.
package tasc_pkg;

    // Fixed field widths
    localparam int ANG_W      = 14;
    localparam int POS_W      = 8;
    localparam int SRV_W      = 2 * POS_W;
    localparam int ENC_W      = 2 * ANG_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ENC_W;
    localparam int TICK_W     = 8;

    // Mapping arithmetic widths
    localparam int DIFF_W = ANG_W + 1;          // signed angle offset
    localparam int SPAN_W = POS_W + 1;          // signed servo span
    localparam int PROD_W = DIFF_W + SPAN_W;    // signed product
    localparam int NUM_W  = ANG_W + POS_W;      // product magnitude
    localparam int DEN_W  = ANG_W;              // encoder span magnitude

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AX1_SERVO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AX1_ENCODER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AX2_SERVO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AX2_ENCODER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 3'd5;

    // Configuration reset values
    localparam logic [SRV_W-1:0]  SERVO_BOUNDS_RST   = 16'hB400;
    localparam logic [ENC_W-1:0]  ENCODER_BOUNDS_RST = 28'hFFFC000;
    localparam logic [TICK_W-1:0] PERIOD_RST         = 8'd20;
    localparam logic [TICK_W-1:0] TICKS_MAX          = 8'hFF;

    // Item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // Result from one axis lane
    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] pos;
    } t_lane_out;

endpackage

[src/tasc_cmd_if.sv]
// Command channel: one tick or one direct target load per item.
// Depends on tasc_pkg for field widths.
interface tasc_cmd_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic                      follow_mode;
    logic                      axis1_up;
    logic                      axis1_down;
    logic                      axis2_up;
    logic                      axis2_down;
    logic [tasc_pkg::ANG_W-1:0] axis1_angle;
    logic [tasc_pkg::ANG_W-1:0] axis2_angle;
    logic [tasc_pkg::POS_W-1:0] axis1_load_value;
    logic [tasc_pkg::POS_W-1:0] axis2_load_value;

    modport source (
        output valid, kind, follow_mode, axis1_up, axis1_down, axis2_up, axis2_down,
               axis1_angle, axis2_angle, axis1_load_value, axis2_load_value,
        input  ready
    );
    modport sink (
        input  valid, kind, follow_mode, axis1_up, axis1_down, axis2_up, axis2_down,
               axis1_angle, axis2_angle, axis1_load_value, axis2_load_value,
        output ready
    );
endinterface

[src/tasc_res_if.sv]
// Result channel: commanded positions of both axes.
// Depends on tasc_pkg for field widths.
interface tasc_res_if;
    logic                      valid;
    logic                      ready;
    logic [tasc_pkg::POS_W-1:0] axis1_position;
    logic [tasc_pkg::POS_W-1:0] axis2_position;
    logic                      from_follow;

    modport source (
        output valid, axis1_position, axis2_position, from_follow,
        input  ready
    );
    modport sink (
        input  valid, axis1_position, axis2_position, from_follow,
        output ready
    );
endinterface

[src/tasc_cfg_if.sv]
// Configuration write channel: register index and write data.
// Depends on tasc_pkg for field widths.
interface tasc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tasc_pkg::CFG_IDX_W-1:0]  index;
    logic [tasc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/tasc_divider.sv]
// Unsigned restoring divider, one quotient bit per cycle.
// No package dependency; widths come from parameters.
module tasc_divider #(
    parameter int N_W = 22,
    parameter int D_W = 14
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [N_W-1:0] o_quot
);
    localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(N_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [D_W-1:0]   r_rem;
    logic [N_W-1:0]   r_quo;
    logic [D_W-1:0]   r_den;

    logic [D_W:0]     w_trial;
    logic             w_fit;
    logic [D_W:0]     w_diff;

    // One trial subtraction per cycle
    assign w_trial = {r_rem, r_quo[N_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: numerator shifts out the top, quotient bits shift in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[D_W-1:0] : w_trial[D_W-1:0];
            r_quo <= {r_quo[N_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

[src/tasc_lane.sv]
// One axis lane: maps an encoder angle onto the servo span with a clamped quotient.
// Depends on tasc_pkg and tasc_divider.
module tasc_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tasc_pkg::ANG_W-1:0]    i_angle,
    input  logic [tasc_pkg::SRV_W-1:0]    i_servo_bounds,
    input  logic [tasc_pkg::ENC_W-1:0]    i_enc_bounds,
    output tasc_pkg::t_lane_out           o_lane
);
    localparam int ANG_W  = tasc_pkg::ANG_W;
    localparam int POS_W  = tasc_pkg::POS_W;
    localparam int DIFF_W = tasc_pkg::DIFF_W;
    localparam int SPAN_W = tasc_pkg::SPAN_W;
    localparam int PROD_W = tasc_pkg::PROD_W;
    localparam int NUM_W  = tasc_pkg::NUM_W;
    localparam int DEN_W  = tasc_pkg::DEN_W;

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_MUL  = 4'b0010,
        L_SGN  = 4'b0100,
        L_DIV  = 4'b1000
    } t_lstate;

    t_lstate r_state, n_state;

    logic signed [DIFF_W-1:0] r_diff;
    logic signed [SPAN_W-1:0] r_span;
    logic signed [DIFF_W-1:0] r_espan;
    logic [POS_W-1:0]         r_smin;
    logic [POS_W-1:0]         r_smax;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_neg;
    logic                     r_empty;
    logic                     r_done;
    logic [POS_W-1:0]         r_pos;

    logic [POS_W-1:0]         w_smin;
    logic [POS_W-1:0]         w_smax;
    logic [ANG_W-1:0]         w_emin;
    logic [ANG_W-1:0]         w_emax;
    logic signed [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0]        w_pmag;
    logic [DIFF_W-1:0]        w_emag;
    logic                     w_start_div;
    logic                     w_div_done;
    logic [NUM_W-1:0]         w_quot;
    logic [POS_W-1:0]         w_pos;

    assign w_smin = i_servo_bounds[POS_W-1:0];
    assign w_smax = i_servo_bounds[2*POS_W-1:POS_W];
    assign w_emin = i_enc_bounds[ANG_W-1:0];
    assign w_emax = i_enc_bounds[2*ANG_W-1:ANG_W];

    // Signed product, registered before the divider
    assign w_prod = r_diff * r_span;

    // Magnitudes for the unsigned divider
    assign w_pmag      = r_prod[PROD_W-1] ? (-r_prod) : r_prod;
    assign w_emag      = r_espan[DIFF_W-1] ? (-r_espan) : r_espan;
    assign w_start_div = (r_state == L_SGN);

    tasc_divider #(
        .N_W (NUM_W),
        .D_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_div),
        .i_num   (w_pmag[NUM_W-1:0]),
        .i_den   (w_emag[DEN_W-1:0]),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Clamp: an empty span or a negative quotient gives the minimum, beyond the span gives the maximum
    always_comb begin
        if (r_empty || r_neg) begin
            w_pos = r_smin;
        end else if (w_quot > NUM_W'(r_span[POS_W-1:0])) begin
            w_pos = r_smax;
        end else begin
            w_pos = r_smin + w_quot[POS_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            L_IDLE:  if (i_start) n_state = L_MUL;
            L_MUL:   n_state = L_SGN;
            L_SGN:   n_state = L_DIV;
            L_DIV:   if (w_div_done) n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == L_DIV) && w_div_done;
        end
    end

    // Operand capture, product and sign, final position
    always_ff @(posedge i_clk) begin
        if (r_state == L_IDLE && i_start) begin
            r_diff  <= $signed({1'b0, i_angle}) - $signed({1'b0, w_emin});
            r_span  <= $signed({1'b0, w_smax}) - $signed({1'b0, w_smin});
            r_espan <= $signed({1'b0, w_emax}) - $signed({1'b0, w_emin});
            r_smin  <= w_smin;
            r_smax  <= w_smax;
        end
        if (r_state == L_MUL) begin
            r_prod  <= w_prod;
            r_empty <= (r_span[SPAN_W-1] || r_span == '0 || r_espan == '0);
        end
        if (r_state == L_SGN) begin
            r_neg <= (r_prod != '0) && (r_prod[PROD_W-1] ^ r_espan[DIFF_W-1]);
        end
        if (r_state == L_DIV && w_div_done) begin
            r_pos <= w_pos;
        end
    end

    assign o_lane.done = r_done;
    assign o_lane.pos  = r_pos;
endmodule

[src/two_axis_servo_command.sv]
// Two-axis servo command generator: follow ticks use two mapping lanes, manual ticks jog.
// Follow ticks pass S_MAP (both lanes) and S_EMIT, manual moves go straight to S_EMIT; a load
// gives no result. Throughput: one item at a time; the input stays busy through S_MAP, set
// by the one-bit-per-cycle divider in each lane (22 steps), and until S_EMIT has moved the
// result into the output register under back-pressure; a load or other tick leaves it ready.
// Reset (synchronous, active low): targets to the initial position, tick count saturated,
// configuration registers to their defaults, result register empty.
module two_axis_servo_command #(
    parameter int MIN_POSITION     = 0,
    parameter int MAX_POSITION     = 180,
    parameter int INITIAL_POSITION = 90
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tasc_cmd_if.sink   i_cmd,
    tasc_res_if.source o_res,
    tasc_cfg_if.sink   i_cfg
);
    localparam int POS_W  = tasc_pkg::POS_W;
    localparam int TICK_W = tasc_pkg::TICK_W;
    localparam logic [POS_W-1:0] POS_MIN  = POS_W'(MIN_POSITION);
    localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_POSITION);
    localparam logic [POS_W-1:0] POS_INIT = POS_W'(INITIAL_POSITION);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MAP  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic                         r_calibrated;
    logic [tasc_pkg::SRV_W-1:0]   r_ax1_servo;
    logic [tasc_pkg::ENC_W-1:0]   r_ax1_enc;
    logic [tasc_pkg::SRV_W-1:0]   r_ax2_servo;
    logic [tasc_pkg::ENC_W-1:0]   r_ax2_enc;
    logic [TICK_W-1:0]            r_period;

    // Block state
    logic [POS_W-1:0]  r_tgt1, n_tgt1;
    logic [POS_W-1:0]  r_tgt2, n_tgt2;
    logic [TICK_W-1:0] r_ticks, n_ticks;

    // Pending result and output register
    logic [POS_W-1:0] r_pend1, n_pend1;
    logic [POS_W-1:0] r_pend2, n_pend2;
    logic             r_pend_follow, n_pend_follow;
    logic             r_out_valid;
    logic [POS_W-1:0] r_out1;
    logic [POS_W-1:0] r_out2;
    logic             r_out_follow;

    logic                w_accept;
    logic                w_start;
    logic                w_emit;
    logic [TICK_W-1:0]   w_ticks_inc;
    logic [POS_W-1:0]    w_jog1;
    logic [POS_W-1:0]    w_jog2;
    tasc_pkg::t_lane_out w_lane1;
    tasc_pkg::t_lane_out w_lane2;

    function automatic logic [POS_W-1:0] jog_step(
        input logic [POS_W-1:0] tgt,
        input logic             up,
        input logic             down,
        input logic [POS_W-1:0] lo,
        input logic [POS_W-1:0] hi
    );
        logic [POS_W-1:0] t;
        t = tgt;
        if (down && t > lo) t = t - 1'b1;
        if (up && t < hi)   t = t + 1'b1;
        return t;
    endfunction

    assign i_cmd.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_start     = w_accept && (i_cmd.kind == tasc_pkg::KIND_TICK)
                         && i_cmd.follow_mode && r_calibrated;
    assign w_emit      = (r_state == S_EMIT) && (!r_out_valid || o_res.ready);

    assign w_ticks_inc = (r_ticks == tasc_pkg::TICKS_MAX) ? r_ticks : r_ticks + 1'b1;
    assign w_jog1 = jog_step(r_tgt1, i_cmd.axis1_up, i_cmd.axis1_down, POS_MIN, POS_MAX);
    assign w_jog2 = jog_step(r_tgt2, i_cmd.axis2_up, i_cmd.axis2_down, POS_MIN, POS_MAX);

    // Axis lanes
    tasc_lane u_lane1 (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_start),
        .i_angle        (i_cmd.axis1_angle),
        .i_servo_bounds (r_ax1_servo),
        .i_enc_bounds   (r_ax1_enc),
        .o_lane         (w_lane1)
    );

    tasc_lane u_lane2 (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_start),
        .i_angle        (i_cmd.axis2_angle),
        .i_servo_bounds (r_ax2_servo),
        .i_enc_bounds   (r_ax2_enc),
        .o_lane         (w_lane2)
    );

    // Item handling and lane merge
    always_comb begin
        n_state       = r_state;
        n_tgt1        = r_tgt1;
        n_tgt2        = r_tgt2;
        n_ticks       = r_ticks;
        n_pend1       = r_pend1;
        n_pend2       = r_pend2;
        n_pend_follow = r_pend_follow;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_cmd.kind == tasc_pkg::KIND_LOAD) begin
                        n_tgt1 = i_cmd.axis1_load_value;
                        n_tgt2 = i_cmd.axis2_load_value;
                    end else begin
                        n_ticks = w_ticks_inc;
                        if (w_start) begin
                            n_state = S_MAP;
                        end else if (w_ticks_inc >= r_period) begin
                            n_ticks       = '0;
                            n_tgt1        = w_jog1;
                            n_tgt2        = w_jog2;
                            n_pend1       = w_jog1;
                            n_pend2       = w_jog2;
                            n_pend_follow = 1'b0;
                            n_state       = S_EMIT;
                        end
                    end
                end
            end
            S_MAP: begin
                if (w_lane1.done && w_lane2.done) begin
                    n_tgt1        = w_lane1.pos;
                    n_tgt2        = w_lane2.pos;
                    n_pend1       = w_lane1.pos;
                    n_pend2       = w_lane2.pos;
                    n_pend_follow = 1'b1;
                    n_state       = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_emit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tgt1      <= POS_INIT;
            r_tgt2      <= POS_INIT;
            r_ticks     <= tasc_pkg::TICKS_MAX;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tgt1  <= n_tgt1;
            r_tgt2  <= n_tgt2;
            r_ticks <= n_ticks;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend1       <= n_pend1;
        r_pend2       <= n_pend2;
        r_pend_follow <= n_pend_follow;
        if (w_emit) begin
            r_out1       <= r_pend1;
            r_out2       <= r_pend2;
            r_out_follow <= r_pend_follow;
        end
    end

    // Configuration register decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calibrated <= 1'b0;
            r_ax1_servo  <= tasc_pkg::SERVO_BOUNDS_RST;
            r_ax1_enc    <= tasc_pkg::ENCODER_BOUNDS_RST;
            r_ax2_servo  <= tasc_pkg::SERVO_BOUNDS_RST;
            r_ax2_enc    <= tasc_pkg::ENCODER_BOUNDS_RST;
            r_period     <= tasc_pkg::PERIOD_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                tasc_pkg::CFG_CALIBRATED:  r_calibrated <= i_cfg.data[0];
                tasc_pkg::CFG_AX1_SERVO:   r_ax1_servo  <= i_cfg.data[tasc_pkg::SRV_W-1:0];
                tasc_pkg::CFG_AX1_ENCODER: r_ax1_enc    <= i_cfg.data[tasc_pkg::ENC_W-1:0];
                tasc_pkg::CFG_AX2_SERVO:   r_ax2_servo  <= i_cfg.data[tasc_pkg::SRV_W-1:0];
                tasc_pkg::CFG_AX2_ENCODER: r_ax2_enc    <= i_cfg.data[tasc_pkg::ENC_W-1:0];
                tasc_pkg::CFG_PERIOD:      r_period     <= i_cfg.data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.axis1_position = r_out1;
    assign o_res.axis2_position = r_out2;
    assign o_res.from_follow    = r_out_follow;
endmodule

[tb/tb.sv]
// Testbench for two_axis_servo_command: ticks, direct loads and register writes go in,
// and each commanded position pair is predicted and checked in order on the result channel.
// Depends on tasc_pkg and the command, result and configuration interfaces under src.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANG_W      = tasc_pkg::ANG_W;
    localparam int POS_W      = tasc_pkg::POS_W;
    localparam int SRV_W      = tasc_pkg::SRV_W;
    localparam int ENC_W      = tasc_pkg::ENC_W;
    localparam int TICK_W     = tasc_pkg::TICK_W;
    localparam int CFG_IDX_W  = tasc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = tasc_pkg::CFG_DATA_W;

    localparam int MIN_POS       = 0;
    localparam int MAX_POS       = 180;
    localparam int INIT_POS      = 90;
    localparam int ANG_MAX       = (1 << ANG_W) - 1;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 5000;
    localparam int RECONFIG_EVERY = 150;

    // jog request bits: {axis1 up, axis1 down, axis2 up, axis2 down}
    localparam logic [3:0] JOG_NONE = 4'b0000;
    localparam logic [3:0] J_A1_UP  = 4'b1000;
    localparam logic [3:0] J_A1_DN  = 4'b0100;
    localparam logic [3:0] J_A2_UP  = 4'b0010;
    localparam logic [3:0] J_A2_DN  = 4'b0001;

    typedef struct packed {
        logic             kind;
        logic             follow;
        logic             a1_up;
        logic             a1_dn;
        logic             a2_up;
        logic             a2_dn;
        logic [ANG_W-1:0] a1_ang;
        logic [ANG_W-1:0] a2_ang;
        logic [POS_W-1:0] a1_load;
        logic [POS_W-1:0] a2_load;
    } t_servo_cmd;

    typedef struct packed {
        logic [POS_W-1:0] a1_pos;
        logic [POS_W-1:0] a2_pos;
        logic             follow;
    } t_servo_pos;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tasc_cmd_if cmd_if ();
    tasc_res_if res_if ();
    tasc_cfg_if cfg_if ();

    two_axis_servo_command #(
        .MIN_POSITION     (MIN_POS),
        .MAX_POSITION     (MAX_POS),
        .INITIAL_POSITION (INIT_POS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // shadow registers and state of the block
    logic             calib;
    logic [SRV_W-1:0] ax1_srv, ax2_srv;
    logic [ENC_W-1:0] ax1_enc, ax2_enc;
    logic [TICK_W-1:0] jog_period;
    logic [POS_W-1:0] ax1_tgt, ax2_tgt;
    logic [TICK_W-1:0] idle_ticks;

    t_servo_pos pos_expect_q[$];
    t_servo_pos pos_want;
    int err_count    = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int quiet_cycles = 0;

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result back-pressure
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // watchdog: no handshake on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result checker: oldest expectation first
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pos_expect_q.size() == 0) begin
                $error("unexpected item: axis1_position %0d axis2_position %0d from_follow %0d",
                       res_if.axis1_position, res_if.axis2_position, res_if.from_follow);
                err_count++;
            end else begin
                pos_want = pos_expect_q.pop_front();
                if (res_if.axis1_position !== pos_want.a1_pos) begin
                    $error("axis1_position: expected %0d, actual %0d",
                           pos_want.a1_pos, res_if.axis1_position);
                    err_count++;
                end
                if (res_if.axis2_position !== pos_want.a2_pos) begin
                    $error("axis2_position: expected %0d, actual %0d",
                           pos_want.a2_pos, res_if.axis2_position);
                    err_count++;
                end
                if (res_if.from_follow !== pos_want.follow) begin
                    $error("from_follow: expected %0d, actual %0d",
                           pos_want.follow, res_if.from_follow);
                    err_count++;
                end
            end
        end
    end

    // linear map of one encoder angle onto the servo span, clamped
    function automatic logic [POS_W-1:0] follow_map(logic [ANG_W-1:0] ang,
                                                    logic [SRV_W-1:0] srv,
                                                    logic [ENC_W-1:0] enc);
        int smin, smax, emin, emax, pos;
        smin = int'(srv[POS_W-1:0]);
        smax = int'(srv[SRV_W-1:POS_W]);
        emin = int'(enc[ANG_W-1:0]);
        emax = int'(enc[ENC_W-1:ANG_W]);
        if (smax - smin <= 0 || emax == emin) return smin[POS_W-1:0];
        // signed quotient truncates toward zero
        pos = smin + ((int'(ang) - emin) * (smax - smin)) / (emax - emin);
        if (pos < smin) pos = smin;
        if (pos > smax) pos = smax;
        return pos[POS_W-1:0];
    endfunction

    // one jog step: decrement first, then increment
    function automatic logic [POS_W-1:0] jog_step(logic [POS_W-1:0] tgt, logic up, logic dn);
        if (dn && tgt > MIN_POS) tgt = tgt - 1'b1;
        if (up && tgt < MAX_POS) tgt = tgt + 1'b1;
        return tgt;
    endfunction

    // next commanded positions for one accepted item; returns 1 when an item comes out
    function automatic bit servo_predict(t_servo_cmd c, output t_servo_pos r);
        r = '0;
        if (c.kind == tasc_pkg::KIND_LOAD) begin
            ax1_tgt = c.a1_load;
            ax2_tgt = c.a2_load;
            return 1'b0;
        end
        if (idle_ticks != tasc_pkg::TICKS_MAX) idle_ticks = idle_ticks + 1'b1;
        if (c.follow && calib) begin
            ax1_tgt = follow_map(c.a1_ang, ax1_srv, ax1_enc);
            ax2_tgt = follow_map(c.a2_ang, ax2_srv, ax2_enc);
            r = '{a1_pos: ax1_tgt, a2_pos: ax2_tgt, follow: 1'b1};
            return 1'b1;
        end
        if (idle_ticks < jog_period) return 1'b0;
        idle_ticks = '0;
        ax1_tgt = jog_step(ax1_tgt, c.a1_up, c.a1_dn);
        ax2_tgt = jog_step(ax2_tgt, c.a2_up, c.a2_dn);
        r = '{a1_pos: ax1_tgt, a2_pos: ax2_tgt, follow: 1'b0};
        return 1'b1;
    endfunction

    function automatic void reset_shadow();
        calib      = 1'b0;
        ax1_srv    = tasc_pkg::SERVO_BOUNDS_RST;
        ax2_srv    = tasc_pkg::SERVO_BOUNDS_RST;
        ax1_enc    = tasc_pkg::ENCODER_BOUNDS_RST;
        ax2_enc    = tasc_pkg::ENCODER_BOUNDS_RST;
        jog_period = tasc_pkg::PERIOD_RST;
        ax1_tgt    = POS_W'(INIT_POS);
        ax2_tgt    = POS_W'(INIT_POS);
        idle_ticks = tasc_pkg::TICKS_MAX;
    endfunction

    function automatic t_servo_cmd tick_cmd(logic follow, logic [3:0] jogs,
                                            logic [ANG_W-1:0] ang1, logic [ANG_W-1:0] ang2);
        t_servo_cmd c;
        c = '0;
        c.kind = tasc_pkg::KIND_TICK;
        c.follow = follow;
        {c.a1_up, c.a1_dn, c.a2_up, c.a2_dn} = jogs;
        c.a1_ang = ang1;
        c.a2_ang = ang2;
        return c;
    endfunction

    function automatic t_servo_cmd load_cmd(logic [POS_W-1:0] v1, logic [POS_W-1:0] v2);
        t_servo_cmd c;
        c = t_servo_cmd'({$urandom, $urandom});
        c.kind = tasc_pkg::KIND_LOAD;
        c.a1_load = v1;
        c.a2_load = v2;
        return c;
    endfunction

    function automatic logic [ANG_W-1:0] rand_angle();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return ANG_W'($urandom);
        endcase
    endfunction

    function automatic t_servo_cmd rand_cmd();
        t_servo_cmd c;
        c = t_servo_cmd'({$urandom, $urandom});
        c.kind = ($urandom_range(9) == 0) ? tasc_pkg::KIND_LOAD : tasc_pkg::KIND_TICK;
        c.follow = ($urandom_range(9) < 6);
        c.a1_ang = rand_angle();
        c.a2_ang = rand_angle();
        return c;
    endfunction

    function automatic logic [SRV_W-1:0] rand_servo_bounds();
        int lo, hi;
        lo = $urandom_range(200);
        hi = $urandom_range(255, lo + 1);
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return 16'hFF00;
            3: return SRV_W'($urandom);
            default: return {hi[POS_W-1:0], lo[POS_W-1:0]};
        endcase
    endfunction

    function automatic logic [ENC_W-1:0] rand_encoder_bounds();
        int lo, hi;
        lo = $urandom_range(ANG_MAX - 1);
        hi = $urandom_range(ANG_MAX, lo + 1);
        case ($urandom_range(6))
            0: return '0;
            1: return '1;
            2: return {ANG_W'(0), ANG_W'(ANG_MAX)};
            3: return ENC_W'($urandom);
            4: return {lo[ANG_W-1:0], hi[ANG_W-1:0]};     // reversed span
            default: return {hi[ANG_W-1:0], lo[ANG_W-1:0]};
        endcase
    endfunction

    // send one command item and record what it should produce
    task automatic send_cmd(t_servo_cmd c);
        t_servo_pos r;
        int gap;
        cmd_if.kind             <= c.kind;
        cmd_if.follow_mode      <= c.follow;
        cmd_if.axis1_up         <= c.a1_up;
        cmd_if.axis1_down       <= c.a1_dn;
        cmd_if.axis2_up         <= c.a2_up;
        cmd_if.axis2_down       <= c.a2_dn;
        cmd_if.axis1_angle      <= c.a1_ang;
        cmd_if.axis2_angle      <= c.a2_ang;
        cmd_if.axis1_load_value <= c.a1_load;
        cmd_if.axis2_load_value <= c.a2_load;
        cmd_if.valid            <= 1'b1;
        do @(posedge i_clk); while (!cmd_if.ready);
        if (servo_predict(c, r)) pos_expect_q.push_back(r);
        gap = 0;
        while (gap < 8 && $urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending, let every expected item arrive, then let the block go quiet
    task automatic wait_idle();
        if (cmd_if.valid) cmd_if.valid <= 1'b0;
        while (pos_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            tasc_pkg::CFG_CALIBRATED:  calib      = val[0];
            tasc_pkg::CFG_AX1_SERVO:   ax1_srv    = val[SRV_W-1:0];
            tasc_pkg::CFG_AX1_ENCODER: ax1_enc    = val[ENC_W-1:0];
            tasc_pkg::CFG_AX2_SERVO:   ax2_srv    = val[SRV_W-1:0];
            tasc_pkg::CFG_AX2_ENCODER: ax2_enc    = val[ENC_W-1:0];
            tasc_pkg::CFG_PERIOD:      jog_period = val[TICK_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // defaults: first tick moves at once, follow ignored while uncalibrated
    task automatic test_reset_state();
        send_cmd(tick_cmd(1'b1, J_A1_UP | J_A2_UP, ANG_W'(ANG_MAX), ANG_W'(ANG_MAX)));
        send_cmd(tick_cmd(1'b0, J_A1_DN | J_A2_DN, '0, '0));
        send_cmd(load_cmd(8'd0, 8'd255));
        wait_idle();
    endtask

    // jog limits, both directions at once, out-of-range loads, zero and short periods
    task automatic test_manual_jog();
        write_reg(tasc_pkg::CFG_PERIOD, CFG_DATA_W'(0));
        send_cmd(tick_cmd(1'b0, J_A1_DN | J_A2_UP, '0, '0));
        send_cmd(tick_cmd(1'b0, J_A1_UP | J_A2_DN, '0, '0));
        send_cmd(load_cmd(8'd180, 8'd179));
        send_cmd(tick_cmd(1'b0, J_A1_UP | J_A2_UP | J_A2_DN, '0, '0));
        send_cmd(tick_cmd(1'b0, JOG_NONE, '0, '0));
        send_cmd(load_cmd(8'd255, 8'd0));
        send_cmd(tick_cmd(1'b0, J_A1_UP | J_A1_DN | J_A2_DN, '0, '0));
        wait_idle();
        write_reg(tasc_pkg::CFG_PERIOD, CFG_DATA_W'(2));
        send_cmd(tick_cmd(1'b0, J_A2_UP, '0, '0));
        send_cmd(tick_cmd(1'b0, J_A2_UP, '0, '0));
        send_cmd(tick_cmd(1'b0, J_A2_UP, '0, '0));
        wait_idle();
    endtask

    // follow mapping: full, reversed, empty and narrow spans with clamping
    task automatic test_follow_map();
        write_reg(tasc_pkg::CFG_CALIBRATED, CFG_DATA_W'(1));
        send_cmd(tick_cmd(1'b1, JOG_NONE, '0, ANG_W'(ANG_MAX)));
        send_cmd(tick_cmd(1'b1, J_A1_UP, ANG_W'(8191), ANG_W'(1)));
        wait_idle();
        write_reg(tasc_pkg::CFG_AX1_ENCODER, {ANG_W'(0), ANG_W'(ANG_MAX)});
        write_reg(tasc_pkg::CFG_AX2_SERVO, CFG_DATA_W'(16'h0AC8));
        send_cmd(tick_cmd(1'b1, JOG_NONE, '0, ANG_W'(5000)));
        send_cmd(tick_cmd(1'b1, JOG_NONE, ANG_W'(ANG_MAX), '0));
        wait_idle();
        write_reg(tasc_pkg::CFG_AX1_SERVO, CFG_DATA_W'(16'hFF00));
        write_reg(tasc_pkg::CFG_AX1_ENCODER, {ANG_W'(2000), ANG_W'(1000)});
        write_reg(tasc_pkg::CFG_AX2_SERVO, CFG_DATA_W'(16'h4D4D));
        write_reg(tasc_pkg::CFG_AX2_ENCODER, {ANG_W'(5), ANG_W'(5)});
        send_cmd(tick_cmd(1'b1, JOG_NONE, ANG_W'(500), '0));
        send_cmd(tick_cmd(1'b1, JOG_NONE, ANG_W'(1500), ANG_W'(ANG_MAX)));
        send_cmd(tick_cmd(1'b1, JOG_NONE, ANG_W'(ANG_MAX), ANG_W'(5)));
        send_cmd(tick_cmd(1'b0, J_A1_DN | J_A2_UP, '0, '0));
        wait_idle();
        write_reg(tasc_pkg::CFG_CALIBRATED, CFG_DATA_W'(0));
        send_cmd(tick_cmd(1'b1, J_A1_DN, ANG_W'(1500), '0));
        send_cmd(tick_cmd(1'b1, J_A1_DN, ANG_W'(1500), '0));
        wait_idle();
    endtask

    task automatic randomize_config();
        int period;
        case ($urandom_range(9))
            0: period = 0;
            1: period = 255;
            2: period = $urandom_range(255);
            default: period = $urandom_range(4, 1);
        endcase
        write_reg(tasc_pkg::CFG_CALIBRATED, CFG_DATA_W'($urandom_range(3) != 0));
        write_reg(tasc_pkg::CFG_AX1_SERVO, CFG_DATA_W'(rand_servo_bounds()));
        write_reg(tasc_pkg::CFG_AX1_ENCODER, rand_encoder_bounds());
        write_reg(tasc_pkg::CFG_AX2_SERVO, CFG_DATA_W'(rand_servo_bounds()));
        write_reg(tasc_pkg::CFG_AX2_ENCODER, rand_encoder_bounds());
        write_reg(tasc_pkg::CFG_PERIOD, CFG_DATA_W'(period));
    endtask

    // random items under changing settings; the sender drains before each change
    task automatic test_random(int n_items, int src_pct, int snk_pct);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int i = 0; i < n_items; i++) begin
            if (i % RECONFIG_EVERY == 0) begin
                wait_idle();
                randomize_config();
            end
            send_cmd(rand_cmd());
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n                 <= 1'b0;
        cmd_if.valid            <= 1'b0;
        cmd_if.kind             <= tasc_pkg::KIND_TICK;
        cmd_if.follow_mode      <= 1'b0;
        cmd_if.axis1_up         <= 1'b0;
        cmd_if.axis1_down       <= 1'b0;
        cmd_if.axis2_up         <= 1'b0;
        cmd_if.axis2_down       <= 1'b0;
        cmd_if.axis1_angle      <= '0;
        cmd_if.axis2_angle      <= '0;
        cmd_if.axis1_load_value <= '0;
        cmd_if.axis2_load_value <= '0;
        cfg_if.valid            <= 1'b0;
        cfg_if.index            <= tasc_pkg::CFG_CALIBRATED;
        cfg_if.data             <= '0;
        reset_shadow();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_manual_jog();
        test_follow_map();
        test_random(600, 30, 67);
        test_random(600, 67, 30);
        test_random(600, 0, 0);

        if (err_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
